[sv/lsr_pkg.sv]
// Shared types and constants of the LR shift-reduce parse engine.
`timescale 1ns / 1ps
package lsr_pkg;
	localparam int unsigned STATE_W    = 8;
	localparam int unsigned SYM_W      = 6;
	localparam int unsigned RULE_W     = 8;
	localparam int unsigned LEN_W      = 4;
	localparam int unsigned DEPTH_W    = 7;
	localparam int unsigned STACK_DEPTH = 64;
	localparam int unsigned STK_AW     = $clog2(STACK_DEPTH);
	localparam int unsigned MAX_REDUCTIONS = 63;
	localparam int unsigned RED_W      = $clog2(MAX_REDUCTIONS + 1);
	localparam int unsigned TBL_AW     = STATE_W + SYM_W;
	localparam int unsigned TBL_DEPTH  = 1 << TBL_AW;

	// Input command codes
	localparam logic [2:0] CMD_WR_ACTION = 3'd0;
	localparam logic [2:0] CMD_WR_GOTO   = 3'd1;
	localparam logic [2:0] CMD_WR_RULE   = 3'd2;
	localparam logic [2:0] CMD_TOKEN     = 3'd3;
	localparam logic [2:0] CMD_RESTART   = 3'd4;

	// Action entry kinds
	localparam logic [1:0] KIND_ERROR  = 2'd0;
	localparam logic [1:0] KIND_SHIFT  = 2'd1;
	localparam logic [1:0] KIND_REDUCE = 2'd2;
	localparam logic [1:0] KIND_ACCEPT = 2'd3;

	// Event codes
	localparam logic [1:0] EV_SHIFT  = 2'd0;
	localparam logic [1:0] EV_REDUCE = 2'd1;
	localparam logic [1:0] EV_ACCEPT = 2'd2;
	localparam logic [1:0] EV_FAIL   = 2'd3;

	typedef enum logic [2:0] {
		OP_WR_ACTION,
		OP_WR_GOTO,
		OP_WR_RULE,
		OP_TOKEN,
		OP_RESTART
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [STATE_W-1:0] table_state;
		logic [SYM_W-1:0]   symbol;
		logic [1:0]         action_kind;
		logic [STATE_W-1:0] target;
		logic [RULE_W-1:0]  rule_number;
		logic [LEN_W-1:0]   rule_length;
		logic [SYM_W-1:0]   rule_lhs;
	} req_t;

	typedef enum logic [1:0] {
		PS_RUNNING,
		PS_ACCEPTED,
		PS_FAILED
	} pstat_t;

	typedef enum logic [2:0] {
		E_CLEAR,
		E_IDLE,
		E_FAIL,
		E_LOOK,
		E_ACT,
		E_RULE,
		E_STK,
		E_GOTO
	} eng_state_t;
endpackage

[sv/lr_shift_reduce_parser.sv]
// Top level of the LR shift-reduce parse engine.
`timescale 1ns / 1ps
// Requests enter on the s_ stream: tuser carries the command (write action,
// write goto, write rule, token, restart), tdata the table and rule fields.
// Results leave on the m_ stream, one per shift, reduce, accept or fail;
// tlast marks the final result of a token. table_ready sits at APB address 0.
// A front decoder feeds a two-entry queue; the back sequencer runs each
// request. Writes and restart are done in the idle state. A token goes
// through a lookup and an action step, and each reduce is a chain of
// action, rule, stack and goto memory reads before the next lookup.
// After reset the action and goto tables are cleared, one entry per cycle,
// all 16384 entries, while s_tready stays low; APB writes are taken.
// The stack then holds state 0 and the parse is running.
// A stalled receiver holds the result register; the sequencer waits and
// the queue fills, then s_tready drops.
module lr_shift_reduce_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // table_state, symbol, action_kind, target,
	                               // rule_number, rule_length, rule_lhs, zero pad
	input  logic [2:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // rule_used, new_state, stack_depth, zero pad
	output logic [1:0]  m_tuser,   // event_res
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lsr_pkg::*;

	logic table_ready_q;
	logic clearing;
	logic req_valid, req_ready;
	req_t req;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_ready_q <= 1'b0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			table_ready_q <= pwdata[0];
		end
	end
	assign prdata = paddr[2] ? 32'd0 : {31'd0, table_ready_q};

	lsr_front u_front (
		.clk(clk), .arst_n(arst_n), .hold(clearing),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.req_valid(req_valid), .req_ready(req_ready), .req(req)
	);

	lsr_engine u_engine (
		.clk(clk), .arst_n(arst_n), .table_ready(table_ready_q),
		.clearing(clearing),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
	);
endmodule

[sv/lsr_front.sv]
// Front end: accepts input requests, decodes the command and queues them.
`timescale 1ns / 1ps
module lsr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hold,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,
	input  logic [2:0]        s_tuser,
	output logic              req_valid,
	input  logic              req_ready,
	output lsr_pkg::req_t     req
);
	import lsr_pkg::*;

	req_t        q_mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        known;
	req_t        dec;
	logic        push, pop;

	// Decode the command; unknown codes are dropped
	always_comb begin
		known = 1'b1;
		dec.op = OP_TOKEN;
		unique case (s_tuser)
			CMD_WR_ACTION: dec.op = OP_WR_ACTION;
			CMD_WR_GOTO:   dec.op = OP_WR_GOTO;
			CMD_WR_RULE:   dec.op = OP_WR_RULE;
			CMD_TOKEN:     dec.op = OP_TOKEN;
			CMD_RESTART:   dec.op = OP_RESTART;
			default:       known = 1'b0;
		endcase
		dec.table_state = s_tdata[7:0];
		dec.symbol      = s_tdata[13:8];
		dec.action_kind = s_tdata[15:14];
		dec.target      = s_tdata[23:16];
		dec.rule_number = s_tdata[31:24];
		dec.rule_length = s_tdata[35:32];
		dec.rule_lhs    = s_tdata[41:36];
	end

	assign s_tready  = (count_q != 2'd2) && !hold;
	assign push      = s_tvalid && s_tready && known;
	assign req_valid = (count_q != 2'd0);
	assign pop       = req_valid && req_ready;
	assign req       = q_mem_q[rd_ptr_q];

	// Two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= dec;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("push into full queue");
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> count_q <= $past(count_q)) else $error("queue grew while held");
endmodule

[sv/lsr_engine.sv]
// Back end: table memories, state stack and the parse sequencer.
`timescale 1ns / 1ps
module lsr_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              table_ready,
	output logic              clearing,
	input  logic              req_valid,
	output logic              req_ready,
	input  lsr_pkg::req_t     req,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);
	import lsr_pkg::*;

	// Memories
	logic [9:0]         act_mem  [TBL_DEPTH];
	logic [STATE_W-1:0] goto_mem [TBL_DEPTH];
	logic [LEN_W-1:0]   len_mem  [1 << RULE_W];
	logic [SYM_W-1:0]   lhs_mem  [1 << RULE_W];
	logic [STATE_W-1:0] stk_mem  [STACK_DEPTH];

	eng_state_t          state_q, state_d;
	pstat_t              pstat_q, pstat_d;
	logic [TBL_AW-1:0]   clr_q;
	logic [STATE_W-1:0]  top_q, top_d;
	logic [DEPTH_W-1:0]  sp_q, sp_d;
	logic [DEPTH_W-1:0]  base_q, base_d;
	logic [SYM_W-1:0]    sym_q, sym_d;
	logic [SYM_W-1:0]    lhs_q, lhs_d;
	logic [RED_W-1:0]    red_q, red_d;
	logic                stk_zero_q;

	logic [9:0]          act_rd_q;
	logic [LEN_W-1:0]    len_rd_q;
	logic [SYM_W-1:0]    lhs_rd_q;
	logic [STATE_W-1:0]  stk_rd_q;
	logic [STATE_W-1:0]  goto_rd_q;

	logic                out_valid_q;
	logic [1:0]          out_ev_q;
	logic [RULE_W-1:0]   out_rule_q;
	logic [STATE_W-1:0]  out_state_q;
	logic [DEPTH_W-1:0]  out_depth_q;
	logic                out_last_q;

	logic                emit;
	logic [1:0]          em_ev;
	logic [RULE_W-1:0]   em_rule;
	logic                em_last;
	logic                out_free;

	logic                act_we, goto_we, rule_we, stk_we;
	logic [TBL_AW-1:0]   tbl_waddr;
	logic [9:0]          act_wdata;
	logic [STATE_W-1:0]  goto_wdata;
	logic [STK_AW-1:0]   stk_waddr;
	logic [STATE_W-1:0]  stk_wdata;
	logic [DEPTH_W-1:0]  rule_base;
	logic [STK_AW-1:0]   stk_raddr;
	logic [STATE_W-1:0]  stk_val;

	assign out_free  = !out_valid_q || m_tready;
	assign clearing  = (state_q == E_CLEAR);
	assign rule_base = sp_q - {{(DEPTH_W-LEN_W){1'b0}}, len_rd_q};
	assign stk_raddr = rule_base[STK_AW-1:0] - {{(STK_AW-1){1'b0}}, 1'b1};
	assign stk_val   = stk_zero_q ? '0 : stk_rd_q;

	// Sequencer: next state, memory writes and result emission
	always_comb begin
		state_d = state_q;
		pstat_d = pstat_q;
		top_d = top_q;
		sp_d = sp_q;
		base_d = base_q;
		sym_d = sym_q;
		lhs_d = lhs_q;
		red_d = red_q;
		req_ready = 1'b0;
		emit = 1'b0;
		em_ev = EV_FAIL;
		em_rule = '0;
		em_last = 1'b1;
		act_we = 1'b0;
		goto_we = 1'b0;
		rule_we = 1'b0;
		stk_we = 1'b0;
		tbl_waddr = {req.table_state, req.symbol};
		act_wdata = {req.action_kind, req.target};
		goto_wdata = req.target;
		stk_waddr = sp_q[STK_AW-1:0];
		stk_wdata = act_rd_q[7:0];
		unique case (state_q)
			E_CLEAR: begin
				act_we = 1'b1;
				goto_we = 1'b1;
				tbl_waddr = clr_q;
				act_wdata = '0;
				goto_wdata = '0;
				if (clr_q == {TBL_AW{1'b1}}) state_d = E_IDLE;
			end
			E_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req.op)
						OP_WR_ACTION: act_we = 1'b1;
						OP_WR_GOTO:   goto_we = 1'b1;
						OP_WR_RULE:   rule_we = 1'b1;
						OP_RESTART: begin
							top_d = '0;
							sp_d = DEPTH_W'(1);
							pstat_d = PS_RUNNING;
						end
						OP_TOKEN: begin
							sym_d = req.symbol;
							red_d = '0;
							if (!table_ready || pstat_q != PS_RUNNING) state_d = E_FAIL;
							else state_d = E_LOOK;
						end
						default: ;
					endcase
				end
			end
			E_FAIL: begin
				if (out_free) begin
					emit = 1'b1;
					pstat_d = PS_FAILED;
					state_d = E_IDLE;
				end
			end
			E_LOOK: state_d = E_ACT;
			E_ACT: begin
				unique case (act_rd_q[9:8])
					KIND_SHIFT: begin
						if (sp_q >= DEPTH_W'(STACK_DEPTH)) state_d = E_FAIL;
						else if (out_free) begin
							stk_we = 1'b1;
							top_d = act_rd_q[7:0];
							sp_d = sp_q + DEPTH_W'(1);
							emit = 1'b1;
							em_ev = EV_SHIFT;
							state_d = E_IDLE;
						end
					end
					KIND_REDUCE: begin
						if (red_q >= RED_W'(MAX_REDUCTIONS)) state_d = E_FAIL;
						else state_d = E_RULE;
					end
					KIND_ACCEPT: begin
						if (out_free) begin
							emit = 1'b1;
							em_ev = EV_ACCEPT;
							pstat_d = PS_ACCEPTED;
							state_d = E_IDLE;
						end
					end
					default: state_d = E_FAIL;
				endcase
			end
			E_RULE: begin
				lhs_d = lhs_rd_q;
				base_d = rule_base;
				// underflow, or the goto push would land past the top of the stack
				if ({{(DEPTH_W-LEN_W){1'b0}}, len_rd_q} >= sp_q ||
					rule_base >= DEPTH_W'(STACK_DEPTH)) state_d = E_FAIL;
				else state_d = E_STK;
			end
			E_STK: state_d = E_GOTO;
			E_GOTO: begin
				if (out_free) begin
					stk_we = 1'b1;
					stk_waddr = base_q[STK_AW-1:0];
					stk_wdata = goto_rd_q;
					top_d = goto_rd_q;
					sp_d = base_q + DEPTH_W'(1);
					red_d = red_q + RED_W'(1);
					emit = 1'b1;
					em_ev = EV_REDUCE;
					em_rule = act_rd_q[7:0];
					em_last = 1'b0;
					state_d = E_LOOK;
				end
			end
			default: state_d = E_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_CLEAR;
			pstat_q <= PS_RUNNING;
			clr_q <= '0;
			top_q <= '0;
			sp_q <= DEPTH_W'(1);
			red_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pstat_q <= pstat_d;
			if (state_q == E_CLEAR) clr_q <= clr_q + TBL_AW'(1);
			top_q <= top_d;
			sp_q <= sp_d;
			red_q <= red_d;
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		base_q <= base_d;
		sym_q <= sym_d;
		lhs_q <= lhs_d;
		stk_zero_q <= (stk_raddr == '0);
		if (emit) begin
			out_ev_q <= em_ev;
			out_rule_q <= em_rule;
			out_state_q <= top_d;
			out_depth_q <= sp_d;
			out_last_q <= em_last;
		end
	end

	// Memory ports, read data registered
	always_ff @(posedge clk) begin
		if (act_we) act_mem[tbl_waddr] <= act_wdata;
		if (goto_we) goto_mem[tbl_waddr] <= goto_wdata;
		if (rule_we) begin
			len_mem[req.rule_number] <= req.rule_length;
			lhs_mem[req.rule_number] <= req.rule_lhs;
		end
		if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
		act_rd_q <= act_mem[{top_q, sym_q}];
		len_rd_q <= len_mem[act_rd_q[7:0]];
		lhs_rd_q <= lhs_mem[act_rd_q[7:0]];
		stk_rd_q <= stk_mem[stk_raddr];
		goto_rd_q <= goto_mem[{stk_val, lhs_q}];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_depth_q, out_state_q, out_rule_q};
	assign m_tuser  = out_ev_q;
	assign m_tlast  = out_last_q;

	a_sp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q != '0 && sp_q <= DEPTH_W'(STACK_DEPTH)) else $error("stack pointer out of range");
	a_no_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == E_CLEAR |-> !emit && !req_ready) else $error("activity during clear");
	a_red_bound: assert property (@(posedge clk) disable iff (!arst_n)
		red_q <= RED_W'(MAX_REDUCTIONS)) else $error("reduction count overrun");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free) else $error("result overwritten");
endmodule

[sim/lr_shift_reduce_parser_tb.sv]
// Self-checking testbench for the LR shift-reduce parse engine.
`timescale 1ns / 1ps
module lr_shift_reduce_parser_tb;
	import lsr_pkg::*;

	typedef struct packed {
		logic [1:0] ev;
		logic [7:0] rule;
		logic [7:0] top;
		logic [6:0] depth;
		logic       last;
	} parse_event_t;

	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 300;
	localparam int REQ_W = $bits(req_t);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	lr_shift_reduce_parser dut (.*);

	always #5 clk = ~clk;

	// Stimulus and expectation stores
	req_t         req_q[$];
	parse_event_t event_q[$];
	byte unsigned rules_written[$];
	int           send_idle = 0;
	int           recv_stall = 0;
	int           errors = 0;
	int           n_requests = 0;
	int           n_tokens = 0;
	int           n_events = 0;

	// Mirror of the engine state
	logic [9:0] act_mem [TBL_DEPTH];
	logic [7:0] goto_mem [TBL_DEPTH];
	logic [3:0] rule_len [256];
	logic [5:0] rule_lhs [256];
	logic [7:0] stk [STACK_DEPTH];
	int         sp;
	pstat_t     status;
	bit         tables_ok;

	task automatic add_event(logic [1:0] ev, logic [7:0] rule, logic last);
		parse_event_t pe;
		pe = '{ev, rule, stk[sp-1], 7'(sp), last};
		event_q = {event_q, pe};
	endtask

	task automatic parse_fail();
		status = PS_FAILED;
		add_event(EV_FAIL, 8'd0, 1'b1);
	endtask

	// Walk one token through ACTION/GOTO until shift, accept or failure
	task automatic parse_token(logic [5:0] sym);
		int         nred;
		int         len;
		int         base;
		bit         done;
		logic [9:0] e;
		if (!tables_ok || status != PS_RUNNING) begin
			parse_fail();
			return;
		end
		nred = 0;
		done = 0;
		while (!done) begin
			e = act_mem[{stk[sp-1], sym}];
			case (e[9:8])
				KIND_SHIFT: begin
					if (sp >= STACK_DEPTH) parse_fail();
					else begin
						stk[sp] = e[7:0];
						sp++;
						add_event(EV_SHIFT, 8'd0, 1'b1);
					end
					done = 1;
				end
				KIND_REDUCE: begin
					len = int'(rule_len[e[7:0]]);
					if (nred >= MAX_REDUCTIONS || len >= sp || sp - len >= STACK_DEPTH) begin
						parse_fail();
						done = 1;
					end else begin
						base = sp - len;
						stk[base] = goto_mem[{stk[base-1], rule_lhs[e[7:0]]}];
						sp = base + 1;
						nred++;
						add_event(EV_REDUCE, e[7:0], 1'b0);
					end
				end
				KIND_ACCEPT: begin
					status = PS_ACCEPTED;
					add_event(EV_ACCEPT, 8'd0, 1'b1);
					done = 1;
				end
				default: begin
					parse_fail();
					done = 1;
				end
			endcase
		end
	endtask

	task automatic apply_request(req_t r);
		n_requests++;
		case (r.op)
			OP_WR_ACTION: act_mem[{r.table_state, r.symbol}] = {r.action_kind, r.target};
			OP_WR_GOTO:   goto_mem[{r.table_state, r.symbol}] = r.target;
			OP_WR_RULE: begin
				rule_len[r.rule_number] = r.rule_length;
				rule_lhs[r.rule_number] = r.rule_lhs;
			end
			OP_TOKEN: begin
				n_tokens++;
				parse_token(r.symbol);
			end
			OP_RESTART: begin
				stk[0] = 8'd0;
				sp = 1;
				status = PS_RUNNING;
			end
			default: ;
		endcase
	endtask

	// Request builders
	function automatic req_t noise_req();
		req_t r;
		r = req_t'(REQ_W'({$urandom(), $urandom()}));
		return r;
	endfunction

	task automatic put_action(int st, int sym, logic [1:0] kind, int tgt);
		req_t r;
		r = noise_req();
		r.op = OP_WR_ACTION;
		r.table_state = 8'(st);
		r.symbol = 6'(sym);
		r.action_kind = kind;
		r.target = 8'(tgt);
		req_q = {req_q, r};
	endtask

	task automatic put_goto(int st, int sym, int tgt);
		req_t r;
		r = noise_req();
		r.op = OP_WR_GOTO;
		r.table_state = 8'(st);
		r.symbol = 6'(sym);
		r.target = 8'(tgt);
		req_q = {req_q, r};
	endtask

	task automatic put_rule(int num, int len, int lhs);
		req_t r;
		r = noise_req();
		r.op = OP_WR_RULE;
		r.rule_number = 8'(num);
		r.rule_length = 4'(len);
		r.rule_lhs = 6'(lhs);
		req_q = {req_q, r};
		rules_written = {rules_written, 8'(num)};
	endtask

	task automatic put_op(op_t op, int sym);
		req_t r;
		r = noise_req();
		r.op = op;
		r.symbol = 6'(sym);
		req_q = {req_q, r};
	endtask

	// Mostly a small grammar region so parses go deep; some full-range noise
	task automatic gen_random(int n);
		int    pick;
		int    st;
		int    sym;
		logic [1:0] kind;
		req_t  r;
		repeat (n) begin
			pick = $urandom_range(99);
			st = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(7);
			sym = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(3);
			if (pick < 35) put_op(OP_TOKEN, sym);
			else if (pick < 60) begin
				kind = 2'($urandom_range(3));
				if (kind == KIND_REDUCE)
					put_action(st, sym, kind,
						rules_written[$urandom_range(rules_written.size() - 1)]);
				else put_action(st, sym, kind, $urandom_range(7));
			end else if (pick < 70) put_goto(st, sym, $urandom_range(7));
			else if (pick < 78) put_rule($urandom_range(255), $urandom_range(3),
				$urandom_range(63));
			else if (pick < 86) put_op(OP_RESTART, 0);
			else if (pick < 92) put_rule($urandom_range(255), $urandom_range(15),
				$urandom_range(63));
			else begin
				// noise: unknown commands, restarts and full-range tokens
				r = noise_req();
				if (r.op inside {OP_WR_ACTION, OP_WR_GOTO, OP_WR_RULE}) r.op = op_t'(3'd5);
				req_q = {req_q, r};
			end
		end
	endtask

	function automatic logic [47:0] pack_req(req_t r);
		return {6'd0, r.rule_lhs, r.rule_length, r.rule_number, r.target,
			r.action_kind, r.symbol, r.table_state};
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) apply_request(req_q.pop_front());
			if (s_tvalid && !s_tready) ;
			else if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				s_tvalid <= 1'b1;
				s_tdata <= pack_req(req_q[0]);
				s_tuser <= req_q[0].op;
			end else s_tvalid <= 1'b0;
		end
	end

	// Long receiver hold-off, counted here
	bit hold_req = 0;
	bit hold_on = 0;
	int hold_cnt = 0;
	always @(posedge clk) begin
		if (hold_req && hold_cnt < HOLD_CYCLES) begin
			hold_on <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else hold_on <= 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= !hold_on && ($urandom_range(99) >= recv_stall);
	end

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Result monitor
	always @(posedge clk) begin
		parse_event_t x;
		if (arst_n && m_tvalid && m_tready) begin
			n_events++;
			if (event_q.size() == 0) report("unexpected result, event", int'(m_tuser), -1);
			else begin
				x = event_q.pop_front();
				if (m_tuser != x.ev) report("event", int'(m_tuser), int'(x.ev));
				if (m_tdata[7:0] != x.rule)
					report("rule_used", int'(m_tdata[7:0]), int'(x.rule));
				if (m_tdata[15:8] != x.top)
					report("new_state", int'(m_tdata[15:8]), int'(x.top));
				if (m_tdata[22:16] != x.depth)
					report("stack_depth", int'(m_tdata[22:16]), int'(x.depth));
				if (m_tlast != x.last) report("last", int'(m_tlast), int'(x.last));
			end
		end
	end

	task automatic write_ready(bit v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'd0;
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tables_ok = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		wait (req_q.size() == 0 && !s_tvalid && event_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(int s, int r);
		@(negedge clk);
		send_idle = s;
		recv_stall = r;
	endtask

	initial begin
		foreach (act_mem[i]) begin
			act_mem[i] = '0;
			goto_mem[i] = '0;
		end
		foreach (stk[i]) stk[i] = '0;
		sp = 1;
		status = PS_RUNNING;
		tables_ok = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Tables not ready: a token must fail
		@(negedge clk);
		put_op(OP_TOKEN, 1);
		put_op(OP_RESTART, 0);
		settle();
		write_ready(1);

		// Directed: shift, reduce, accept, error, underflow, reduction limit
		@(negedge clk);
		put_rule(0, 1, 1);
		put_rule(1, 0, 2);
		put_rule(3, 0, 4);
		put_rule(255, 15, 63);
		put_action(0, 1, KIND_SHIFT, 5);
		put_action(5, 2, KIND_REDUCE, 0);
		put_goto(0, 1, 7);
		put_action(7, 2, KIND_ACCEPT, 0);
		put_op(OP_TOKEN, 1);
		put_op(OP_TOKEN, 2);
		put_op(OP_TOKEN, 2);
		put_op(OP_RESTART, 0);
		put_action(0, 3, KIND_REDUCE, 1);
		put_goto(0, 2, 0);
		put_op(OP_TOKEN, 3);
		put_op(OP_RESTART, 0);
		put_action(0, 4, KIND_REDUCE, 255);
		put_op(OP_TOKEN, 4);
		put_op(OP_RESTART, 0);
		put_op(OP_TOKEN, 63);
		put_op(OP_RESTART, 0);
		put_action(255, 63, KIND_SHIFT, 255);
		put_goto(255, 63, 255);
		put_action(0, 5, KIND_SHIFT, 255);
		put_op(OP_TOKEN, 5);
		put_op(OP_TOKEN, 63);
		put_op(op_t'(3'd7), 0);
		put_op(OP_RESTART, 0);
		// stack grows by empty reductions until it is full
		put_action(5, 3, KIND_REDUCE, 3);
		put_goto(5, 4, 5);
		put_op(OP_TOKEN, 1);
		put_op(OP_TOKEN, 3);
		put_op(OP_RESTART, 0);
		// shift until the stack overflows
		put_action(0, 6, KIND_SHIFT, 200);
		put_action(200, 6, KIND_SHIFT, 200);
		repeat (64) put_op(OP_TOKEN, 6);
		put_op(OP_RESTART, 0);
		settle();

		// Random phases with different idling
		@(negedge clk);
		gen_random(5);
		settle();
		set_idling(82, 0);
		gen_random(5);
		settle();
		write_ready(0);
		@(negedge clk);
		put_op(OP_TOKEN, 1);
		put_op(OP_RESTART, 0);
		settle();
		write_ready(1);
		set_idling(0, 82);
		gen_random(5);
		settle();

		// Receiver holds off while tokens keep coming
		@(negedge clk);
		hold_req = 1;
		put_op(OP_RESTART, 0);
		repeat (12) put_op(OP_TOKEN, 3);
		put_op(OP_RESTART, 0);
		settle();

		set_idling(22, 22);
		gen_random(5);
		put_op(OP_RESTART, 0);
		settle();

		if (event_q.size() != 0) report("results never seen", 0, event_q.size());
		$display("covered %0d requests, %0d tokens, %0d results checked",
			n_requests, n_tokens, n_events);
		$display("idling phases run, long receiver hold-off done, table_ready toggled");
		if (errors == 0) $display("PASS lr_shift_reduce_parser");
		else $display("FAIL lr_shift_reduce_parser");
		$finish;
	end

	// Overall limit
	initial begin
		#8_000_000;
		$display("timeout");
		$display("FAIL lr_shift_reduce_parser");
		$finish;
	end
endmodule
